// File: src/sbps_pkg.sv
// Package for the streaming byte pattern search: widths, word types and
// configuration register indexes. Used by every module of the block.
`timescale 1ns / 1ps

package sbps_pkg;

   // Longest pattern the block can hold.
   localparam int MAX_PATTERN = 16;
   localparam int HIST_DEPTH  = MAX_PATTERN - 1;
   localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
   localparam int FILL_W      = $clog2(MAX_PATTERN);

   localparam int BYTE_W      = 8;
   localparam int CFG_LEN_W   = 5;
   localparam int CFG_DATA_W  = 64;
   localparam int CFG_INDEX_W = 2;
   localparam int POS_W       = 32;
   localparam int PREFIX_W    = 5;

   localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 2'd0;
   localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW    = 2'd1;
   localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH   = 2'd2;

   typedef logic [MAX_PATTERN-1:0][BYTE_W-1:0] byte_array_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              restart;
   } req_word_type;

   typedef struct packed {
      logic                match_found;
      logic [POS_W-1:0]    match_start;
      logic [PREFIX_W-1:0] prefix_length;
   } rsp_word_type;

endpackage

// File: src/sbps_cfg.sv
// Configuration registers of the pattern search: pattern length and bytes.
// Presents the clamped active length and the pattern as a byte array.
`timescale 1ns / 1ps

module sbps_cfg
   import sbps_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic [CFG_INDEX_W-1:0] csr_index,
   input  logic [CFG_DATA_W-1:0]  csr_data,
   output logic [LEN_W-1:0]       active_length,
   output byte_array_type         pattern
);

   logic [CFG_LEN_W-1:0]  length_ff;
   logic [CFG_DATA_W-1:0] low_ff;
   logic [CFG_DATA_W-1:0] high_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= CFG_LEN_W'(1);
         low_ff    <= '0;
         high_ff   <= '0;
      end else if (csr_write) begin
         // Writes to indexes past the last register are dropped.
         unique case (csr_index)
            REG_PATTERN_LENGTH: length_ff <= csr_data[CFG_LEN_W-1:0];
            REG_PATTERN_LOW:    low_ff    <= csr_data;
            REG_PATTERN_HIGH:   high_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (length_ff == '0) begin
         active_length = LEN_W'(1);
      end else if (int'(length_ff) > MAX_PATTERN) begin
         active_length = LEN_W'(MAX_PATTERN);
      end else begin
         active_length = LEN_W'(length_ff);
      end
   end

   for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_pattern
      if (j < 8) begin : g_low
         assign pattern[j] = low_ff[BYTE_W*j +: BYTE_W];
      end else if (j < 16) begin : g_high
         assign pattern[j] = high_ff[BYTE_W*(j-8) +: BYTE_W];
      end else begin : g_zero
         assign pattern[j] = '0;
      end
   end

endmodule

// File: src/sbps_match.sv
// Parallel comparator array: finds the longest pattern prefix that ends at
// the newest byte of the window. Uses sbps_pkg.
`timescale 1ns / 1ps

module sbps_match
   import sbps_pkg::*;
(
   input  byte_array_type   window,
   input  byte_array_type   pattern,
   input  logic [LEN_W-1:0] avail,
   output logic [LEN_W-1:0] best
);

   logic [MAX_PATTERN-1:0] hit;

   // Entry l tests a prefix of l+1 bytes: pattern byte j against the byte
   // l-j steps back in the window.
   always_comb begin
      logic ok;
      for (int l = 0; l < MAX_PATTERN; l++) begin
         ok = (l + 1) <= int'(avail);
         for (int j = 0; j <= l; j++) begin
            ok = ok & (pattern[j] == window[l-j]);
         end
         hit[l] = ok;
      end
   end

   // The longest hit wins.
   always_comb begin
      best = '0;
      for (int l = 0; l < MAX_PATTERN; l++) begin
         if (hit[l]) begin
            best = LEN_W'(l + 1);
         end
      end
   end

endmodule

// File: src/streaming_byte_pattern_search.sv
// Streaming byte pattern search, top level. Holds the input and result
// registers and the stream state; uses sbps_pkg, sbps_cfg and sbps_match.
//
// Usage: bytes enter one word per cycle on the req_ channel (valid/ready),
// each with a restart flag that clears the history, the position and the
// found flag before that byte is taken. For every byte one word leaves on
// the rsp_ channel: the sticky found flag, the start position of the first
// match (zero until found) and the longest pattern prefix ending there.
// The pattern length and bytes are written through the csr_ port, which is
// always ready; write it only while no word is in flight.
//
// Flow: a byte is held in the input register, then passes the comparator
// array into the result register, which drives rsp_valid and the result
// word. Throughput is one byte per cycle while the receiver keeps up, set
// by the single combinational comparator array that decides each byte.
// Reset empties both registers, clears the stream state and loads a
// pattern length of one. When the receiver stalls, the result register
// holds its word, the input register fills, and req_ready falls; nothing
// is lost and the stream state advances only when a result is written.
`timescale 1ns / 1ps

module streaming_byte_pattern_search
   import sbps_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_word_type           req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_word_type           rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CFG_INDEX_W-1:0] csr_index,
   input  logic [CFG_DATA_W-1:0]  csr_data
);

   localparam logic [POS_W-1:0] POS_MAX = '1;

   logic                          in_valid_ff;
   req_word_type                  in_word_ff;
   logic                          out_valid_ff;
   rsp_word_type                  out_word_ff;
   logic [HIST_DEPTH-1:0][BYTE_W-1:0] hist_ff;
   logic [HIST_DEPTH-1:0][BYTE_W-1:0] hist_in;
   logic [FILL_W-1:0]             fill_ff;
   logic [FILL_W-1:0]             fill_in;
   logic [POS_W-1:0]              pos_ff;
   logic [POS_W-1:0]              pos_in;
   logic                          found_ff;
   logic                          found_in;
   logic [POS_W-1:0]              start_ff;
   logic [POS_W-1:0]              start_in;

   logic [LEN_W-1:0]              plen;
   byte_array_type                pattern;
   byte_array_type                window;
   logic [LEN_W-1:0]              avail;
   logic [LEN_W-1:0]              best;
   logic                          advance;
   logic                          full_hit;
   logic [FILL_W-1:0]             eff_fill;
   logic [POS_W-1:0]              eff_pos;
   logic                          eff_found;
   logic [POS_W-1:0]              eff_start;
   rsp_word_type                  out_word_in;

   assign csr_ready = 1'b1;

   sbps_cfg u_cfg (
      .clock         (clock),
      .reset         (reset),
      .csr_write     (csr_valid & csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .active_length (plen),
      .pattern       (pattern)
   );

   assign advance   = in_valid_ff & (~out_valid_ff | rsp_ready);
   assign req_ready = ~in_valid_ff | advance;

   // A restart word sees the cleared state.
   assign eff_fill  = in_word_ff.restart ? '0 : fill_ff;
   assign eff_pos   = in_word_ff.restart ? '0 : pos_ff;
   assign eff_found = in_word_ff.restart ? 1'b0 : found_ff;
   assign eff_start = in_word_ff.restart ? '0 : start_ff;

   always_comb begin
      window[0] = in_word_ff.data_byte;
      for (int i = 1; i < MAX_PATTERN; i++) begin
         window[i] = hist_ff[i-1];
      end
   end

   // Only bytes inside the fill count take part, so stale history is masked.
   always_comb begin
      logic [LEN_W-1:0] have;
      have = LEN_W'(eff_fill) + LEN_W'(1);
      avail = (have > plen) ? plen : have;
   end

   sbps_match u_match (
      .window  (window),
      .pattern (pattern),
      .avail   (avail),
      .best    (best)
   );

   assign full_hit = (best == plen) & ~eff_found;
   assign found_in = eff_found | full_hit;
   assign start_in = full_hit ? (eff_pos - (POS_W'(plen) - POS_W'(1))) : eff_start;
   assign pos_in   = (eff_pos != POS_MAX) ? (eff_pos + POS_W'(1)) : eff_pos;
   assign fill_in  = (int'(eff_fill) < HIST_DEPTH) ? (eff_fill + FILL_W'(1)) : eff_fill;

   always_comb begin
      hist_in[0] = in_word_ff.data_byte;
      for (int i = 1; i < HIST_DEPTH; i++) begin
         hist_in[i] = hist_ff[i-1];
      end
   end

   always_comb begin
      out_word_in.match_found   = found_in;
      out_word_in.match_start   = found_in ? start_in : '0;
      out_word_in.prefix_length = PREFIX_W'(best);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         fill_ff      <= '0;
         pos_ff       <= '0;
         found_ff     <= 1'b0;
         start_ff     <= '0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            fill_ff      <= fill_in;
            pos_ff       <= pos_in;
            found_ff     <= found_in;
            start_ff     <= start_in;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_word_ff <= req_data;
      end
      if (advance) begin
         out_word_ff <= out_word_in;
         hist_ff     <= hist_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_word_ff;

   // The found flag only drops on a restart word.
   a_found_sticky: assert property (@(posedge clock) disable iff (reset)
      found_ff && !(advance && in_word_ff.restart) |=> found_ff)
      else $error("found flag cleared without restart");

   a_start_clear: assert property (@(posedge clock) disable iff (reset)
      !found_ff |-> start_ff == '0)
      else $error("match start set while nothing found");

   a_pos_moves: assert property (@(posedge clock) disable iff (reset)
      advance |=> pos_ff != '0 && fill_ff != '0)
      else $error("position or fill count did not advance");

   a_rsp_start_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_word_ff.match_found |-> out_word_ff.match_start == '0)
      else $error("result carries a start without a match");

endmodule
